[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/b64enc_pkg.sv]
// shared constants and the base64 alphabet mapping for the encoder
// no dependencies
`default_nettype none

package b64enc_pkg;

    localparam int unsigned MAX_CHARS = 5;
    localparam int unsigned CNT_W     = 3;

    localparam logic [7:0] LINEFEED         = 8'h0A;
    localparam logic [7:0] PAD_CHAR         = 8'h3D;
    localparam logic [7:0] LINE_LIMIT_RESET = 8'd76;

    // standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] wide;
        wide = {2'b00, v};
        case (v) inside
            [6'd0:6'd25]:  return wide + 8'h41;
            [6'd26:6'd51]: return wide + 8'h47;
            [6'd52:6'd61]: return wide - 8'd4;
            6'd62:         return 8'h2B;
            default:       return 8'h2F;
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/core/b64enc_ifs.sv]
// valid/ready channel interfaces for the encoder input bytes and output characters
// no dependencies
`default_nettype none

interface b64enc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64enc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

[rtl/core/base64_encoder_line_wrap.sv]
// streaming MIME base64 encoder with line wrapping, one raw byte per input beat
// depends on b64enc_pkg and the channel interfaces in b64enc_ifs.sv
`default_nettype none

// Takes one raw byte per input beat (final_byte marks the end of a message) and
// produces MIME base64 characters, one per output beat, from the standard
// alphabet. Symbols leave as soon as they are known; an incomplete last group is
// padded with one or two '=' characters, and last_char flags the final character
// of the message. After each complete group of four characters the line count
// grows by four, and a linefeed 0x0A follows the group once that sum reaches
// line_limit (reset value 76, written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, the block does not enforce this). After the
// final byte all encoder state returns to zero for the next message.
// Timing: an accepted byte is turned into its whole character list (one to five
// characters) in the same cycle and loaded into a small output shift register.
// The output port moves one character per cycle while out_ch.ready is high, and
// a byte holds the input until its last character leaves; the next byte is taken
// in the cycle the last character of the previous one leaves. No startup sweep
// after reset.
module base64_encoder_line_wrap
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    b64enc_in_if.sink       in_ch,
    b64enc_out_if.source    out_ch,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);

    // position of the next byte within its group of three
    typedef enum logic [1:0]
    {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    // configuration
    logic [7:0] line_limit_reg;

    // encoder state
    phase_t     phase_reg;
    logic [3:0] carry_reg;
    logic [7:0] line_count_reg;

    // output shift register: head is chars_reg[0], count_reg entries pending
    logic [7:0]                      chars_reg [b64enc_pkg::MAX_CHARS];
    logic [b64enc_pkg::CNT_W-1:0]    count_reg;
    logic                            fin_reg;

    // next values computed from the incoming beat
    logic [7:0]                      chars_next [b64enc_pkg::MAX_CHARS];
    logic [b64enc_pkg::CNT_W-1:0]    count_next;
    phase_t                          phase_next;
    logic [3:0]                      carry_next;
    logic [7:0]                      line_count_next;

    logic [5:0]                      sym_a;
    logic [5:0]                      sym_b;
    logic [b64enc_pkg::CNT_W-1:0]    base_cnt;
    logic                            group_end;
    logic [8:0]                      line_sum;
    logic                            wrap_line;
    logic                            fin;
    logic [7:0]                      byte_in;
    logic [7:0]                      base_chars [b64enc_pkg::MAX_CHARS];

    logic                            in_accept;
    logic                            out_take;

    assign byte_in = in_ch.data_byte;
    assign fin     = in_ch.final_byte;

    // ready when nothing is pending or the last pending character leaves now
    assign in_ch.ready = (count_reg == '0)
                      || ((count_reg == b64enc_pkg::CNT_W'(1)) && out_ch.ready);

    assign out_ch.valid     = (count_reg != '0);
    assign out_ch.out_char  = chars_reg[0];
    assign out_ch.last_char = fin_reg && (count_reg == b64enc_pkg::CNT_W'(1));

    assign in_accept = in_ch.valid && in_ch.ready;
    assign out_take  = out_ch.valid && out_ch.ready;

    // split the byte into the symbols of the current group position
    always_comb
    begin
        case (phase_reg)
            PH_FIRST:
            begin
                sym_a      = byte_in[7:2];
                sym_b      = {byte_in[1:0], 4'b0000};
                base_cnt   = fin ? b64enc_pkg::CNT_W'(4) : b64enc_pkg::CNT_W'(1);
                carry_next = {2'b00, byte_in[1:0]};
                phase_next = PH_SECOND;
            end
            PH_SECOND:
            begin
                sym_a      = {carry_reg[1:0], byte_in[7:4]};
                sym_b      = {byte_in[3:0], 2'b00};
                base_cnt   = fin ? b64enc_pkg::CNT_W'(3) : b64enc_pkg::CNT_W'(1);
                carry_next = byte_in[3:0];
                phase_next = PH_THIRD;
            end
            default:
            begin
                // third byte closes the group (an unused code acts the same)
                sym_a      = {carry_reg[3:0], byte_in[7:6]};
                sym_b      = byte_in[5:0];
                base_cnt   = b64enc_pkg::CNT_W'(2);
                carry_next = 4'd0;
                phase_next = PH_FIRST;
            end
        endcase
    end

    // group bookkeeping and linefeed decision
    always_comb
    begin
        group_end = fin || ((phase_reg != PH_FIRST) && (phase_reg != PH_SECOND));
        line_sum  = {1'b0, line_count_reg} + 9'd4;
        wrap_line = group_end && (line_sum >= {1'b0, line_limit_reg});

        if (fin || wrap_line)
        begin
            line_count_next = 8'd0;
        end
        else if (group_end)
        begin
            line_count_next = line_sum[7:0];
        end
        else
        begin
            line_count_next = line_count_reg;
        end

        count_next = base_cnt + {{(b64enc_pkg::CNT_W-1){1'b0}}, wrap_line};
    end

    // character list: symbols, pads, and a linefeed right after the base entries
    always_comb
    begin
        base_chars[0] = b64enc_pkg::sym(sym_a);
        base_chars[1] = b64enc_pkg::sym(sym_b);
        base_chars[2] = b64enc_pkg::PAD_CHAR;
        base_chars[3] = b64enc_pkg::PAD_CHAR;
        base_chars[4] = b64enc_pkg::LINEFEED;
        for (int i = 0; i < b64enc_pkg::MAX_CHARS; i++)
        begin
            chars_next[i] = (b64enc_pkg::CNT_W'(i) == base_cnt) ? b64enc_pkg::LINEFEED
                                                                : base_chars[i];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= b64enc_pkg::LINE_LIMIT_RESET;
            phase_reg      <= PH_FIRST;
            carry_reg      <= 4'd0;
            line_count_reg <= 8'd0;
            count_reg      <= '0;
            fin_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                line_limit_reg <= cfg_wr_data;
            end

            if (in_accept)
            begin
                phase_reg      <= fin ? PH_FIRST : phase_next;
                carry_reg      <= fin ? 4'd0 : carry_next;
                line_count_reg <= line_count_next;
                count_reg      <= count_next;
                fin_reg        <= fin;
            end
            else if (out_take)
            begin
                count_reg <= count_reg - b64enc_pkg::CNT_W'(1);
            end
        end
    end

    // character payload, shifted toward the head as beats leave
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            chars_reg <= chars_next;
        end
        else if (out_take)
        begin
            for (int i = 0; i < b64enc_pkg::MAX_CHARS - 1; i++)
            begin
                chars_reg[i] <= chars_reg[i+1];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/b64enc_checker.sv]
// port-level checks for the base64 encoder, bound to the top level
// depends on assert_macros.svh, b64enc_pkg and base64_encoder_line_wrap
`default_nettype none

`include "assert_macros.svh"

module b64enc_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_char,
    input wire logic       last_char
);

    // a stalled output beat keeps its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(last_char))

    // every accepted byte produces at least one character next cycle
    `ASSERT_NEXT(a_in_makes_out, clk, rst_n, in_valid && in_ready, out_valid)

    // input only stalls while characters are pending
    `ASSERT_IMPL(a_stall_has_out, clk, rst_n, !in_ready, out_valid)

    // a linefeed is always the last character of its byte
    `ASSERT_IMPL(a_lf_frees_input, clk, rst_n, out_valid && out_ready && (out_char == b64enc_pkg::LINEFEED), in_ready)

endmodule

bind base64_encoder_line_wrap b64enc_checker u_b64enc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .last_char (out_ch.last_char)
);

`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench for the line-wrapping base64 encoder
// depends on b64enc_pkg, the channel interfaces in b64enc_ifs.sv and the encoder top level
`timescale 1ns / 1ps

module tb_top;

    // encoder symbol table, first character in the top byte
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // position of the next byte within its group of three
    typedef enum logic [1:0] {
        GRP_FIRST  = 2'd0,
        GRP_SECOND = 2'd1,
        GRP_THIRD  = 2'd2
    } grp_pos_t;

    // one character beat as it should leave the encoder
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } char_beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    b64enc_in_if  in_ch ();
    b64enc_out_if out_ch ();

    base64_encoder_line_wrap u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // encoder state as the testbench tracks it
    logic [7:0] wrap_limit     = b64enc_pkg::LINE_LIMIT_RESET;
    logic [3:0] leftover_bits  = 4'd0;
    grp_pos_t   group_pos      = GRP_FIRST;
    logic [7:0] chars_on_line  = 8'd0;

    char_beat_t expected_chars[$];
    int         mismatches = 0;

    // when set, neither side inserts gaps
    bit calm = 1'b0;

    always #10 clk = ~clk;

    // hard stop in case the encoder hangs or loses characters
    initial
    begin
        #20_000_000;
        $display("base64_encoder_line_wrap test failed");
        $finish;
    end

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        return B64_ALPHABET[8*(63 - v) +: 8];
    endfunction

    // gap length: mostly none, sometimes short, rarely a long pause
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_char(input logic [7:0] c);
        char_beat_t beat;
        beat.out_char  = c;
        beat.last_char = 1'b0;
        expected_chars.push_back(beat);
    endtask

    // a group of four characters is complete: count it, wrap the line if the limit is hit
    // the sum is one bit wider so a count near 255 cannot wrap around
    task automatic close_group();
        logic [8:0] sum;
        sum = {1'b0, chars_on_line} + 9'd4;
        if (sum >= {1'b0, wrap_limit})
        begin
            push_char(b64enc_pkg::LINEFEED);
            chars_on_line = 8'd0;
        end
        else
        begin
            chars_on_line = sum[7:0];
        end
    endtask

    // expected characters for one accepted input byte
    task automatic predict_chars(input logic [7:0] b, input logic fin);
        char_beat_t tail;
        case (group_pos)
            GRP_FIRST:
            begin
                push_char(b64_symbol(b[7:2]));
                if (fin)
                begin
                    // lone byte: two symbols and a double pad
                    push_char(b64_symbol({b[1:0], 4'b0000}));
                    push_char(b64enc_pkg::PAD_CHAR);
                    push_char(b64enc_pkg::PAD_CHAR);
                    close_group();
                end
                else
                begin
                    leftover_bits = {2'b00, b[1:0]};
                    group_pos     = GRP_SECOND;
                end
            end
            GRP_SECOND:
            begin
                push_char(b64_symbol({leftover_bits[1:0], b[7:4]}));
                if (fin)
                begin
                    // two bytes: three symbols and one pad
                    push_char(b64_symbol({b[3:0], 2'b00}));
                    push_char(b64enc_pkg::PAD_CHAR);
                    close_group();
                end
                else
                begin
                    leftover_bits = b[3:0];
                    group_pos     = GRP_THIRD;
                end
            end
            default:
            begin
                push_char(b64_symbol({leftover_bits, b[7:6]}));
                push_char(b64_symbol(b[5:0]));
                leftover_bits = 4'd0;
                group_pos     = GRP_FIRST;
                close_group();
            end
        endcase
        if (fin)
        begin
            // flag the message end, trailing linefeed included, and start afresh
            tail = expected_chars.pop_back();
            tail.last_char = 1'b1;
            expected_chars.push_back(tail);
            leftover_bits = 4'd0;
            group_pos     = GRP_FIRST;
            chars_on_line = 8'd0;
        end
    endtask

    // input beats feed the prediction before output beats are checked,
    // so the order holds even if both fall on the same edge
    always @(posedge clk)
    begin : beat_monitor
        char_beat_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                predict_chars(in_ch.data_byte, in_ch.final_byte);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("out_char: no beat expected, actual 8'h%h", out_ch.out_char);
                    mismatches++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_ch.out_char !== want.out_char)
                    begin
                        $error("out_char: expected 8'h%h, actual 8'h%h",
                               want.out_char, out_ch.out_char);
                        mismatches++;
                    end
                    if (out_ch.last_char !== want.last_char)
                    begin
                        $error("last_char: expected %b, actual %b",
                               want.last_char, out_ch.last_char);
                        mismatches++;
                    end
                end
            end
        end
    end

    // receiver: runs of ready broken by stalls of random length
    initial
    begin : out_ready_driver
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // one input beat; valid stays high into the next call when no gap follows
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.final_byte <= fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            // junk on the data lines while valid is low
            in_ch.valid      <= 1'b0;
            in_ch.data_byte  <= 8'($urandom);
            in_ch.final_byte <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every expected character has come out
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_line_limit(input logic [7:0] lim);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'($urandom);
        wrap_limit = lim;
    endtask

    // random content, final flag on the last byte, an occasional full drain mid-message
    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom), i == len - 1);
            if ($urandom_range(0, 29) == 0)
                wait_idle();
        end
    endtask

    // short messages at the reset limit: both pad lengths, full groups, all-zero and all-one bytes
    task automatic test_padding_cases();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b1);
    endtask

    // a limit of four wraps after every group; a limit under four does too
    task automatic test_small_limits();
        set_line_limit(8'd4);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h3E, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        set_line_limit(8'd3);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hC0, 1'b1);
    endtask

    // limit 255: the count climbs to 252 and the next group must wrap rather than overflow
    task automatic test_long_line();
        set_line_limit(8'd255);
        send_random_message(197);
    endtask

    // limit lowered while a line is already longer than the new value
    task automatic test_limit_mid_line();
        set_line_limit(8'd200);
        for (int i = 0; i < 30; i++)
            send_byte(8'($urandom), 1'b0);
        set_line_limit(8'd8);
        for (int i = 0; i < 6; i++)
            send_byte(8'($urandom), 1'b0);
        set_line_limit(b64enc_pkg::LINE_LIMIT_RESET);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
    endtask

    // mixed message lengths over a spread of limits, extremes favored
    task automatic test_random_messages();
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < 50)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                set_line_limit(8'd4);
            else if (r < 4)
                set_line_limit(8'd255);
            else if (r < 8)
                set_line_limit(8'($urandom_range(5, 40)));
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(40, 80);
            else
                len = $urandom_range(1, 24);
            send_random_message(len);
            sent += len;
        end
    endtask

    // back-to-back beats on both sides
    task automatic test_no_gaps();
        set_line_limit(8'd12);
        calm = 1'b1;
        send_random_message(17);
        send_random_message(22);
        send_random_message(2);
        wait_idle();
        calm = 1'b0;
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 8'd0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'd0;
        in_ch.final_byte = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_padding_cases();
        test_small_limits();
        test_long_line();
        test_limit_mid_line();
        test_random_messages();
        test_no_gaps();

        // everything out, then a short wait to catch stray beats
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("base64_encoder_line_wrap test passed");
        else
            $display("base64_encoder_line_wrap test failed");
        $finish;
    end

endmodule
